[rtl/core/ir_tsp_pkg.sv]
// Shared types and constants of the IR timing symbol packer.
package ir_tsp_pkg;

  localparam int DUR_W  = 20;
  localparam int SYM_W  = 15;
  localparam int CNT_W  = 10;
  localparam int RES_W  = 5;
  localparam int FH_W   = 11;
  localparam int PROD_W = FH_W + SYM_W;

  localparam int DEF_CAPACITY  = 512;
  localparam int DEF_MAX_CHUNK = 32767;
  localparam int MAX_RESULTS   = 18;

  localparam logic [SYM_W-1:0] PAD_DURATION = SYM_W'(1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_CMP,
    ST_CHUNK,
    ST_CLOSE,
    ST_FLUSH
  } tsp_state_e;

  typedef struct packed {
    logic load;
    logic mul;
    logic cmp;
    logic chunk;
    logic close;
    logic flush;
  } tsp_cmd_t;

  typedef struct packed {
    logic no_phase;
    logic pkt_end;
    logic over_cap;
    logic last_chunk;
    logic slot_ok;
    logic cand_vld;
  } tsp_status_t;

  typedef struct packed {
    logic [SYM_W-1:0] first_duration;
    logic             first_level;
    logic [SYM_W-1:0] second_duration;
    logic             second_level;
    logic             symbol_valid;
    logic             truncated;
    logic             last;
  } tsp_result_t;

endpackage

[rtl/core/ir_tsp_ctrl.sv]
// Sequencing state machine of the IR timing symbol packer.
module ir_tsp_ctrl
  import ir_tsp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  tsp_status_t status_i,
  output tsp_cmd_t    cmd_o
);

  tsp_state_e state_q, state_d;

  // Advance the state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Pick the next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_MUL;
      end
      ST_MUL: begin
        state_d = ST_CMP;
      end
      ST_CMP: begin
        if (status_i.no_phase || status_i.over_cap) state_d = ST_CLOSE;
        else state_d = ST_CHUNK;
      end
      ST_CHUNK: begin
        if (status_i.slot_ok && status_i.last_chunk) begin
          state_d = status_i.pkt_end ? ST_CLOSE : ST_FLUSH;
        end
      end
      ST_CLOSE: begin
        if (status_i.slot_ok) state_d = ST_FLUSH;
      end
      ST_FLUSH: begin
        if (!status_i.cand_vld) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Drive commands to the datapath
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_MUL:   cmd_o.mul   = 1'b1;
      ST_CMP:   cmd_o.cmp   = 1'b1;
      ST_CHUNK: cmd_o.chunk = status_i.slot_ok;
      ST_CLOSE: cmd_o.close = status_i.slot_ok;
      ST_FLUSH: cmd_o.flush = 1'b1;
      default: ;
    endcase
  end

  // Only one command at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot0(cmd_o))
    else $error("more than one datapath command");

  // A request is taken only from idle, and work starts next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   cmd_o.load |=> state_q == ST_MUL)
    else $error("request accepted without starting work");

  // A close always leads to a flush of the held result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   cmd_o.close |=> state_q == ST_FLUSH)
    else $error("close not followed by flush");

endmodule

[rtl/core/ir_tsp_dp.sv]
// Datapath of the IR timing symbol packer: packet state, chunking, result staging.
module ir_tsp_dp
  import ir_tsp_pkg::*;
#(
  parameter int CAPACITY  = DEF_CAPACITY,
  parameter int MAX_CHUNK = DEF_MAX_CHUNK
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tsp_cmd_t          cmd_i,
  output tsp_status_t       status_o,
  input  logic [DUR_W-1:0]  duration_i,
  input  logic              level_i,
  input  logic              pkt_end_i,
  input  logic              no_phase_i,
  output tsp_result_t       out_res_o,
  output logic              out_valid_o,
  input  logic              out_ready_i
);

  localparam logic [SYM_W-1:0]  CHUNK_MAX  = SYM_W'(MAX_CHUNK);
  localparam logic [DUR_W-1:0]  CHUNK_DUR  = DUR_W'(MAX_CHUNK);
  localparam logic [CNT_W-1:0]  CAP_CNT    = CNT_W'(CAPACITY);
  localparam logic [RES_W-1:0]  RES_LIMIT  = RES_W'(MAX_RESULTS);

  // Request fields
  logic [DUR_W-1:0]  dur_q, dur_d;
  logic              lvl_q, pe_q, np_q;
  // Packet state
  logic [CNT_W-1:0]  count_q, count_d;
  logic              hp_q, hp_d;
  logic [SYM_W-1:0]  held_dur_q, held_dur_d;
  logic              held_lvl_q, held_lvl_d;
  // Item working state
  logic [PROD_W-1:0] prod_q;
  logic              trunc_q;
  logic [RES_W-1:0]  nres_q, nres_d;
  tsp_result_t       cand_q, cand_d;
  logic              cand_vld_q, cand_vld_d;
  tsp_result_t       out_q, out_d;
  logic              out_vld_q, out_vld_d;

  logic [FH_W-1:0]   room_halves;
  logic [SYM_W-1:0]  chunk;
  logic              last_chunk;
  logic              over_cap;
  logic              out_free;
  logic              put_en;
  logic              stored;
  logic              mark_last;
  logic              flush_move;
  tsp_result_t       put_res;

  // Free halves left in the packet
  always_comb begin
    if (count_q >= CAP_CNT) begin
      room_halves = '0;
    end else begin
      room_halves = ({1'b0, CAP_CNT - count_q} << 1) - FH_W'(hp_q);
    end
  end

  assign over_cap   = {{(PROD_W-DUR_W){1'b0}}, dur_q} > prod_q;
  assign last_chunk = dur_q <= CHUNK_DUR;
  assign chunk      = last_chunk ? dur_q[SYM_W-1:0] : CHUNK_MAX;
  assign out_free   = !out_vld_q || out_ready_i;

  // Select the result that this step produces
  always_comb begin
    put_en    = 1'b0;
    mark_last = 1'b0;
    put_res   = '0;
    if (cmd_i.chunk && hp_q) begin
      put_en  = 1'b1;
      put_res = '{first_duration: held_dur_q, first_level: held_lvl_q,
                  second_duration: chunk, second_level: lvl_q,
                  symbol_valid: 1'b1, truncated: 1'b0, last: 1'b0};
    end else if (cmd_i.close) begin
      if (hp_q) begin
        put_en  = 1'b1;
        put_res = '{first_duration: held_dur_q, first_level: held_lvl_q,
                    second_duration: PAD_DURATION, second_level: 1'b0,
                    symbol_valid: 1'b1, truncated: trunc_q, last: 1'b1};
      end else if (cand_vld_q) begin
        mark_last = 1'b1;
      end else begin
        put_en  = 1'b1;
        put_res = '{first_duration: '0, first_level: 1'b0,
                    second_duration: '0, second_level: 1'b0,
                    symbol_valid: 1'b0, truncated: trunc_q, last: 1'b1};
      end
    end
  end

  // Drop results beyond the per-item limit
  assign stored     = put_en && (nres_q < RES_LIMIT);
  assign flush_move = cmd_i.flush && cand_vld_q && out_free;

  // Update packet state and result staging
  always_comb begin
    dur_d      = dur_q;
    count_d    = count_q;
    hp_d       = hp_q;
    held_dur_d = held_dur_q;
    held_lvl_d = held_lvl_q;
    nres_d     = nres_q;
    cand_d     = cand_q;
    cand_vld_d = cand_vld_q;
    out_d      = out_q;
    out_vld_d  = out_vld_q && !out_ready_i;

    if (cmd_i.load) begin
      dur_d  = (duration_i == '0) ? DUR_W'(1) : duration_i;
      nres_d = '0;
    end

    if (cmd_i.chunk) begin
      dur_d = dur_q - {{(DUR_W-SYM_W){1'b0}}, chunk};
      if (!hp_q) begin
        held_dur_d = chunk;
        held_lvl_d = lvl_q;
        hp_d       = 1'b1;
      end else begin
        count_d = count_q + CNT_W'(1);
        hp_d    = 1'b0;
      end
    end

    if (cmd_i.close) begin
      count_d    = '0;
      hp_d       = 1'b0;
      held_dur_d = '0;
      held_lvl_d = 1'b0;
    end

    if (mark_last) cand_d.last = 1'b1;

    if (stored) begin
      if (cand_vld_q) begin
        out_d     = cand_q;
        out_vld_d = 1'b1;
      end
      cand_d     = put_res;
      cand_vld_d = 1'b1;
      nres_d     = nres_q + RES_W'(1);
    end else if (flush_move) begin
      out_d      = cand_q;
      out_vld_d  = 1'b1;
      cand_vld_d = 1'b0;
    end
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      hp_q       <= 1'b0;
      cand_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
      nres_q     <= '0;
      trunc_q    <= 1'b0;
    end else begin
      count_q    <= count_d;
      hp_q       <= hp_d;
      cand_vld_q <= cand_vld_d;
      out_vld_q  <= out_vld_d;
      nres_q     <= nres_d;
      if (cmd_i.load) trunc_q <= 1'b0;
      else if (cmd_i.cmp) trunc_q <= !np_q && over_cap;
    end
  end

  // Hold payload
  always_ff @(posedge clk_i) begin
    dur_q      <= dur_d;
    held_dur_q <= held_dur_d;
    held_lvl_q <= held_lvl_d;
    cand_q     <= cand_d;
    out_q      <= out_d;
    if (cmd_i.load) begin
      lvl_q <= level_i;
      pe_q  <= pkt_end_i;
      np_q  <= no_phase_i;
    end
    if (cmd_i.mul) begin
      prod_q <= PROD_W'(room_halves) * PROD_W'(MAX_CHUNK);
    end
  end

  assign status_o = '{no_phase: np_q, pkt_end: pe_q, over_cap: over_cap,
                      last_chunk: last_chunk, slot_ok: !cand_vld_q || out_free,
                      cand_vld: cand_vld_q};

  assign out_res_o   = out_q;
  assign out_valid_o = out_vld_q;

  // A staged result is only pushed out when the output slot is free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   stored && cand_vld_q |-> out_free)
    else $error("staged result overwrites pending output");

  // Symbols in a packet never exceed the capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CAP_CNT)
    else $error("symbol count beyond capacity");

  // Per-item results stay within the limit
  assert property (@(posedge clk_i) disable iff (!rst_ni) nres_q <= RES_LIMIT)
    else $error("result count beyond limit");

  // A close returns the packet state to empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   cmd_i.close |=> count_q == '0 && !hp_q)
    else $error("packet state not cleared on close");

endmodule

[rtl/core/ir_timing_symbol_packer.sv]
// Top level of the IR timing symbol packer.
//
// Input channel (in_valid_i / in_ready_o) carries one timing request:
// duration, level, packet end and no-phase flags. Output channel
// (out_valid_o / out_ready_i) carries packed two-phase symbols and
// packet status, one result per transfer.
// One request is worked at a time. After acceptance the block runs a
// capacity check (free halves times chunk size, then a compare), cuts the
// duration into chunks of up to MAX_CHUNK ticks, one chunk per cycle while
// a result slot is free, closes the packet on packet end, no phase or over
// capacity, hands its final result to the output register and returns to
// idle to take the next request.
// Results leave through a staging register and an output register, so the
// last result of a packet can still be marked when the packet closes.
// When the receiver stalls, chunking waits whenever both registers are full;
// a stall drops nothing, but results beyond MAX_RESULTS per request are dropped.
// Reset clears the packet state, both result registers and the sequencer;
// the block is ready for a request as soon as reset is released.
module ir_timing_symbol_packer
  import ir_tsp_pkg::*;
#(
  parameter int CAPACITY  = DEF_CAPACITY,
  parameter int MAX_CHUNK = DEF_MAX_CHUNK
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [DUR_W-1:0] duration_i,
  input  logic             level_i,
  input  logic             pkt_end_i,
  input  logic             no_phase_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [SYM_W-1:0] first_duration_o,
  output logic             first_level_o,
  output logic [SYM_W-1:0] second_duration_o,
  output logic             second_level_o,
  output logic             symbol_valid_o,
  output logic             truncated_o,
  output logic             last_o
);

  tsp_cmd_t    cmd;
  tsp_status_t status;
  tsp_result_t out_res;

  ir_tsp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ir_tsp_dp #(
    .CAPACITY  (CAPACITY),
    .MAX_CHUNK (MAX_CHUNK)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .duration_i   (duration_i),
    .level_i      (level_i),
    .pkt_end_i    (pkt_end_i),
    .no_phase_i   (no_phase_i),
    .out_res_o    (out_res),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i)
  );

  assign first_duration_o  = out_res.first_duration;
  assign first_level_o     = out_res.first_level;
  assign second_duration_o = out_res.second_duration;
  assign second_level_o    = out_res.second_level;
  assign symbol_valid_o    = out_res.symbol_valid;
  assign truncated_o       = out_res.truncated;
  assign last_o            = out_res.last;

endmodule
